### rtl/s5st_pkg.sv
// Package for the S5 sleep-type scanner: scan phase encoding, status codes
// and the byte constants of the name and package grammar. No dependencies.

package s5st_pkg;

  localparam int unsigned LenW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 2;
  localparam int unsigned DataW  = 32;

  // Shortest table that is scanned at all, and the margin a match needs
  // before the end of the table.
  localparam logic [LenW-1:0] MinTableLen = 32'd40;
  localparam logic [LenW:0]   StartMargin = 33'd12;

  localparam logic [AddrW-1:0] AddrTableLength = 2'd0;

  // Name sequence 08 '_' 'S' '5' '_'.
  localparam logic [ByteW-1:0] NameByte0 = 8'h08;
  localparam logic [ByteW-1:0] NameByte1 = 8'h5F;
  localparam logic [ByteW-1:0] NameByte2 = 8'h53;
  localparam logic [ByteW-1:0] NameByte3 = 8'h35;
  localparam logic [ByteW-1:0] NameByte4 = 8'h5F;

  localparam logic [ByteW-1:0] OpScope    = 8'h10;
  localparam logic [ByteW-1:0] OpPackage  = 8'h12;
  localparam logic [ByteW-1:0] OpByteData = 8'h0A;
  localparam logic [ByteW-1:0] OpZero     = 8'h00;

  typedef enum logic [1:0] {
    StNotFound = 2'd0,
    StFound    = 2'd1,
    StBadElem  = 2'd2,
    StTruncated = 2'd3
  } scan_status_e;

  typedef enum logic [13:0] {
    PhSeek   = 14'b00000000000001,
    PhName1  = 14'b00000000000010,
    PhName2  = 14'b00000000000100,
    PhName3  = 14'b00000000001000,
    PhName4  = 14'b00000000010000,
    PhAfter  = 14'b00000000100000,
    PhScoped = 14'b00000001000000,
    PhLead   = 14'b00000010000000,
    PhSkip   = 14'b00000100000000,
    PhAOp    = 14'b00001000000000,
    PhAVal   = 14'b00010000000000,
    PhBOp    = 14'b00100000000000,
    PhBVal   = 14'b01000000000000,
    PhDone   = 14'b10000000000000
  } scan_phase_e;

endpackage

### rtl/aml_s5_sleep_type_scanner.sv
// S5 sleep-type scanner: top level, the whole byte-serial parser.
// Depends on s5st_pkg.

// The block takes the body of a system description table one byte per word
// on the input channel and looks for the '_S5_' name object, then its
// package, and returns the two sleep-type values with a status. Exactly one
// result word is given per table: as soon as the scan concludes, or at the
// table's last byte; later bytes are swallowed without a result. Before a
// table is streamed, table_length must be written at address 0 of the
// configuration port; that write also restarts the scan, as reset does.
// Reset leaves a length of one. Tables shorter than 40 bytes report
// "not found" at their last byte. Throughput is one byte per clock cycle
// while the input is not stalled: each byte passes through a single step of
// the phase logic, and the result is registered: it appears in the output
// register in the cycle after the byte that caused it.
// The input stalls only while a result word waits and the output is stalled.

module aml_s5_sleep_type_scanner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [s5st_pkg::AddrW-1:0]      paddr,
  input  logic [s5st_pkg::DataW-1:0]      pwdata,
  output logic [s5st_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  // Input byte channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [s5st_pkg::ByteW-1:0]      data_byte_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [s5st_pkg::ByteW-1:0]      sleep_type_a_o,
  output logic [s5st_pkg::ByteW-1:0]      sleep_type_b_o,
  output logic [1:0]                      scan_status_o
);

  logic [s5st_pkg::LenW-1:0]  table_length_q;
  logic [s5st_pkg::LenW-1:0]  byte_pos_q, byte_pos_d;
  s5st_pkg::scan_phase_e      phase_q, phase_d;
  logic [1:0]                 len_left_q, len_left_d;
  logic [s5st_pkg::ByteW-1:0] held_a_q, held_a_d;

  logic                       out_valid_q;
  logic [s5st_pkg::ByteW-1:0] res_a_q, res_b_q;
  s5st_pkg::scan_status_e     res_status_q;

  logic                       cfg_write;
  logic                       in_accept;
  logic                       last_byte;
  logic [s5st_pkg::LenW-1:0]  last_pos;
  logic                       start_ok;
  logic [s5st_pkg::ByteW-1:0] b;
  logic                       emit;
  logic [s5st_pkg::ByteW-1:0] emit_a, emit_b;
  s5st_pkg::scan_status_e     emit_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == s5st_pkg::AddrTableLength);
  assign prdata    = (paddr == s5st_pkg::AddrTableLength) ? table_length_q
                                                          : '0;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign b          = data_byte_i;

  // A length of zero behaves as one, so its first byte is the last.
  assign last_pos  = (table_length_q == '0) ? '0 : table_length_q - 1'b1;
  assign last_byte = (byte_pos_q == last_pos);

  // A name match may begin only with room to spare before the table's end.
  assign start_ok = (b == s5st_pkg::NameByte0)
                 && (table_length_q >= s5st_pkg::MinTableLen)
                 && (({1'b0, byte_pos_q} + s5st_pkg::StartMargin) < {1'b0, table_length_q});

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    held_a_d    = held_a_q;
    byte_pos_d  = byte_pos_q + 1'b1;
    emit        = 1'b0;
    emit_a      = '0;
    emit_b      = '0;
    emit_status = s5st_pkg::StNotFound;

    if (phase_q == s5st_pkg::PhDone) begin
      byte_pos_d = byte_pos_q;
    end else if (last_byte && phase_q == s5st_pkg::PhAOp) begin
      // The table ends where the first element should start.
      phase_d     = s5st_pkg::PhDone;
      emit        = 1'b1;
      emit_status = s5st_pkg::StTruncated;
    end else if (last_byte && phase_q == s5st_pkg::PhBOp) begin
      phase_d     = s5st_pkg::PhDone;
      emit        = 1'b1;
      emit_a      = held_a_q;
      emit_status = s5st_pkg::StTruncated;
    end else begin
      unique case (phase_q)
        s5st_pkg::PhSeek, s5st_pkg::PhName1, s5st_pkg::PhName2,
        s5st_pkg::PhName3, s5st_pkg::PhName4: begin
          if (phase_q == s5st_pkg::PhName1 && b == s5st_pkg::NameByte1) begin
            phase_d = s5st_pkg::PhName2;
          end else if (phase_q == s5st_pkg::PhName2 && b == s5st_pkg::NameByte2) begin
            phase_d = s5st_pkg::PhName3;
          end else if (phase_q == s5st_pkg::PhName3 && b == s5st_pkg::NameByte3) begin
            phase_d = s5st_pkg::PhName4;
          end else if (phase_q == s5st_pkg::PhName4 && b == s5st_pkg::NameByte4) begin
            phase_d = s5st_pkg::PhAfter;
          end else if (start_ok) begin
            phase_d  = s5st_pkg::PhName1;
            held_a_d = '0;
          end else begin
            phase_d = s5st_pkg::PhSeek;
          end
        end
        s5st_pkg::PhAfter, s5st_pkg::PhScoped: begin
          if (phase_q == s5st_pkg::PhAfter && b == s5st_pkg::OpScope) begin
            phase_d = s5st_pkg::PhScoped;
          end else if (b == s5st_pkg::OpPackage) begin
            phase_d = s5st_pkg::PhLead;
          end else if (start_ok) begin
            phase_d  = s5st_pkg::PhName1;
            held_a_d = '0;
          end else begin
            phase_d = s5st_pkg::PhSeek;
          end
        end
        s5st_pkg::PhLead: begin
          // Bits 7:6 of the lead byte count the extra package-length bytes.
          len_left_d = b[7:6];
          phase_d    = s5st_pkg::PhSkip;
        end
        s5st_pkg::PhSkip: begin
          if (len_left_q != '0) begin
            len_left_d = len_left_q - 1'b1;
          end else begin
            phase_d = s5st_pkg::PhAOp;
          end
        end
        s5st_pkg::PhAOp: begin
          if (b == s5st_pkg::OpByteData) begin
            phase_d = s5st_pkg::PhAVal;
          end else if (b == s5st_pkg::OpZero) begin
            held_a_d = '0;
            phase_d  = s5st_pkg::PhBOp;
          end else begin
            phase_d     = s5st_pkg::PhDone;
            emit        = 1'b1;
            emit_status = s5st_pkg::StBadElem;
          end
        end
        s5st_pkg::PhAVal: begin
          held_a_d = b;
          phase_d  = s5st_pkg::PhBOp;
        end
        s5st_pkg::PhBOp: begin
          if (b == s5st_pkg::OpByteData) begin
            phase_d = s5st_pkg::PhBVal;
          end else begin
            phase_d     = s5st_pkg::PhDone;
            emit        = 1'b1;
            emit_a      = held_a_q;
            emit_status = s5st_pkg::StFound;
          end
        end
        s5st_pkg::PhBVal: begin
          phase_d     = s5st_pkg::PhDone;
          emit        = 1'b1;
          emit_a      = held_a_q;
          emit_b      = b;
          emit_status = s5st_pkg::StFound;
        end
        default: begin
          phase_d = s5st_pkg::PhSeek;
        end
      endcase

      // At the table's last byte the scan concludes whatever happened above.
      if (last_byte && !emit) begin
        emit = 1'b1;
        if (phase_d == s5st_pkg::PhAfter || phase_d == s5st_pkg::PhScoped
            || phase_d == s5st_pkg::PhLead || phase_d == s5st_pkg::PhSkip
            || phase_d == s5st_pkg::PhAOp || phase_d == s5st_pkg::PhAVal
            || phase_d == s5st_pkg::PhBOp || phase_d == s5st_pkg::PhBVal) begin
          emit_a      = held_a_d;
          emit_status = s5st_pkg::StTruncated;
        end
        phase_d = s5st_pkg::PhDone;
      end
    end
  end

  // Scan state. A length write restarts the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= 32'd1;
      byte_pos_q     <= '0;
      phase_q        <= s5st_pkg::PhSeek;
      len_left_q     <= '0;
      held_a_q       <= '0;
    end else if (cfg_write) begin
      table_length_q <= pwdata;
      byte_pos_q     <= '0;
      phase_q        <= s5st_pkg::PhSeek;
      len_left_q     <= '0;
      held_a_q       <= '0;
    end else if (in_accept) begin
      byte_pos_q <= byte_pos_d;
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      held_a_q   <= held_a_d;
    end
  end

  // Result register: loaded when a byte concludes the scan, held while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      res_a_q      <= emit_a;
      res_b_q      <= emit_b;
      res_status_q <= emit_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sleep_type_a_o = res_a_q;
  assign sleep_type_b_o = res_b_q;
  assign scan_status_o  = res_status_q;

endmodule

### dv/s5_scan_checker.sv
`timescale 1ns / 1ps
// Result checker for the S5 sleep-type scanner: follows the configuration
// port and both word channels, predicts each result word and compares it.
// Depends on s5st_pkg.

module s5_scan_checker
  import s5st_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [ByteW-1:0]  sleep_type_a_o,
  input  logic [ByteW-1:0]  sleep_type_b_o,
  input  logic [1:0]        scan_status_o,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] type_a;
    logic [ByteW-1:0] type_b;
    scan_status_e     status;
  } sleep_result_t;

  sleep_result_t    awaited_q[$];
  sleep_result_t    new_res;
  sleep_result_t    head;
  bit               new_emit;

  logic [LenW-1:0]  scan_len;
  logic [LenW-1:0]  scan_pos;
  scan_phase_e      phase;
  logic [1:0]       extra_left;
  logic [ByteW-1:0] held_a;
  logic [ByteW-1:0] held_b;

  task automatic restart_scan();
    scan_pos   = '0;
    phase      = PhSeek;
    extra_left = '0;
    held_a     = '0;
    held_b     = '0;
  endtask

  // A name match may only open far enough from the end of a long table.
  task automatic try_open(input logic [ByteW-1:0] b, input logic [LenW-1:0] at);
    if (b == NameByte0 && scan_len >= MinTableLen &&
        ({1'b0, at} + StartMargin) < {1'b0, scan_len}) begin
      phase  = PhName1;
      held_a = '0;
      held_b = '0;
    end else begin
      phase = PhSeek;
    end
  endtask

  task automatic conclude(input scan_status_e st, input logic [ByteW-1:0] a,
                          input logic [ByteW-1:0] b, output bit emit,
                          output sleep_result_t res);
    phase       = PhDone;
    emit        = 1'b1;
    res.type_a  = a;
    res.type_b  = b;
    res.status  = st;
  endtask

  task automatic advance_scan(input logic [ByteW-1:0] b, output bit emit,
                              output sleep_result_t res);
    logic [LenW-1:0] at;
    logic [LenW-1:0] end_pos;
    bit              at_end;
    emit       = 1'b0;
    res.type_a = '0;
    res.type_b = '0;
    res.status = StNotFound;
    at         = scan_pos;
    end_pos    = (scan_len == '0) ? '0 : scan_len - 1'b1;
    at_end     = (at == end_pos);
    if (phase == PhDone) return;
    scan_pos = at + 1'b1;
    // The table ends on an element opcode: that byte is not looked at.
    if (at_end && phase == PhAOp) begin
      conclude(StTruncated, '0, '0, emit, res);
      return;
    end
    if (at_end && phase == PhBOp) begin
      conclude(StTruncated, held_a, '0, emit, res);
      return;
    end
    case (phase)
      PhSeek:  try_open(b, at);
      PhName1: if (b == NameByte1) phase = PhName2; else try_open(b, at);
      PhName2: if (b == NameByte2) phase = PhName3; else try_open(b, at);
      PhName3: if (b == NameByte3) phase = PhName4; else try_open(b, at);
      PhName4: if (b == NameByte4) phase = PhAfter; else try_open(b, at);
      PhAfter: begin
        if (b == OpScope) phase = PhScoped;
        else if (b == OpPackage) phase = PhLead;
        else try_open(b, at);
      end
      PhScoped: if (b == OpPackage) phase = PhLead; else try_open(b, at);
      PhLead: begin
        extra_left = b[7:6];
        phase      = PhSkip;
      end
      PhSkip: begin
        if (extra_left != 2'd0) extra_left = extra_left - 2'd1;
        else phase = PhAOp;
      end
      PhAOp: begin
        if (b == OpByteData) begin
          phase = PhAVal;
        end else if (b == OpZero) begin
          held_a = '0;
          phase  = PhBOp;
        end else begin
          conclude(StBadElem, '0, '0, emit, res);
          return;
        end
      end
      PhAVal: begin
        held_a = b;
        phase  = PhBOp;
      end
      PhBOp: begin
        if (b == OpByteData) begin
          phase = PhBVal;
        end else begin
          held_b = '0;
          conclude(StFound, held_a, '0, emit, res);
          return;
        end
      end
      PhBVal: begin
        held_b = b;
        conclude(StFound, held_a, held_b, emit, res);
        return;
      end
      default: phase = PhSeek;
    endcase
    if (at_end) begin
      case (phase)
        PhAfter, PhScoped, PhLead, PhSkip, PhAOp, PhAVal, PhBOp, PhBVal:
          conclude(StTruncated, held_a, '0, emit, res);
        default:
          conclude(StNotFound, '0, '0, emit, res);
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_len = 32'd1;
      restart_scan();
      awaited_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Results are checked before this edge's byte is predicted, since a
      // result can never leave in the cycle its byte arrives.
      if (out_valid_o && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result word: a=%02h b=%02h status=%0d",
                     sleep_type_a_o, sleep_type_b_o, scan_status_o);
          fail_count_o++;
        end else begin
          head = awaited_q.pop_front();
          if (head.type_a != sleep_type_a_o || head.type_b != sleep_type_b_o ||
              head.status != scan_status_o) begin
            if (fail_count_o < 10)
              $display("mismatch: a %02h/%02h b %02h/%02h status %0d/%0d (exp/got)",
                       head.type_a, sleep_type_a_o, head.type_b, sleep_type_b_o,
                       head.status, scan_status_o);
            fail_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == AddrTableLength) begin
        scan_len = pwdata;
        restart_scan();
      end
      if (in_valid_i && !in_stall_o) begin
        advance_scan(data_byte_i, new_emit, new_res);
        if (new_emit) awaited_q.push_back(new_res);
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

### dv/aml_s5_sleep_type_scanner_tb.sv
`timescale 1ns / 1ps
// Top of the S5 sleep-type scanner testbench: clock, reset, stimulus and the
// verdict. Depends on s5st_pkg, the scanner and s5_scan_checker.

module aml_s5_sleep_type_scanner_tb;
  import s5st_pkg::*;

  typedef logic [ByteW-1:0] bytes_t[$];

  // Generous ceiling on the run.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 1800;
  // Both sides idle freely except inside this window of cycles.
  localparam int unsigned QuietFrom  = 1500;
  localparam int unsigned QuietTo    = 3000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ByteW-1:0]  data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ByteW-1:0]  sleep_type_a_o;
  logic [ByteW-1:0]  sleep_type_b_o;
  logic [1:0]        scan_status_o;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cyc;
  int unsigned       payload_count;

  aml_s5_sleep_type_scanner dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sleep_type_a_o (sleep_type_a_o),
    .sleep_type_b_o (sleep_type_b_o),
    .scan_status_o  (scan_status_o)
  );

  s5_scan_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sleep_type_a_o (sleep_type_a_o),
    .sleep_type_b_o (sleep_type_b_o),
    .scan_status_o  (scan_status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // The run is abandoned if it hangs, for example on a result that never
  // comes or a stall that never lifts.
  always @(posedge clk_i) begin
    if (cyc == CycleLimit) begin
      $display("aml_s5_sleep_type_scanner_tb: errors");
      $finish;
    end
  end

  // Either side is idle at random, with a chance of seven in a hundred, except in
  // the quiet window, where words flow back to back.
  function automatic bit may_idle();
    if (cyc >= QuietFrom && cyc < QuietTo) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // The result side stalls at random; all changes fall on the falling edge.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= may_idle();
    end
  end

  // Noise leans on the bytes that the grammar cares about, so that partial
  // names and stray opcodes turn up often.
  function automatic logic [ByteW-1:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return ByteW'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return NameByte0;
      1: return NameByte1;
      2: return NameByte2;
      3: return NameByte3;
      4: return OpScope;
      5: return OpPackage;
      6: return OpByteData;
      default: return OpZero;
    endcase
  endfunction

  // Two-phase write of the table length. The register is taken at the rising
  // edge on which the access phase meets pready.
  task automatic write_length(input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrTableLength;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers the first n bytes of a table, one word each. A word stays on
  // the channel until it is taken.
  task automatic stream_bytes(input bytes_t q, input int n);
    for (int i = 0; i < n; i++) begin
      while (may_idle()) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= q[i];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Waits until every predicted result has come out, and then waits further,
  // as a table that ends without a result may still be on its last byte.
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_table(input logic [DataW-1:0] len, input bytes_t q, input int n);
    settle();
    write_length(len);
    stream_bytes(q, n);
  endtask

  // A name object and its package, mostly well formed. The lead byte's top
  // bits choose how many length bytes follow; the elements are ByteData,
  // Zero or something unrecognised.
  task automatic build_package(inout bytes_t pkg);
    int extra;
    int pick;
    pkg.push_back(NameByte0);
    pkg.push_back(NameByte1);
    pkg.push_back(NameByte2);
    pkg.push_back(NameByte3);
    pkg.push_back(NameByte4);
    if ($urandom_range(0, 1) == 1) pkg.push_back(OpScope);
    if ($urandom_range(0, 9) == 0) pkg.push_back(noise_byte());
    else pkg.push_back(OpPackage);
    extra = $urandom_range(0, 3);
    pkg.push_back({extra[1:0], 6'($urandom_range(0, 63))});
    repeat (extra) pkg.push_back(ByteW'($urandom_range(0, 255)));
    pkg.push_back(ByteW'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pkg.push_back(OpByteData);
      pkg.push_back(ByteW'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      pkg.push_back(OpZero);
    end else begin
      pkg.push_back(noise_byte());
    end
    if ($urandom_range(0, 99) < 60) begin
      pkg.push_back(OpByteData);
      pkg.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      pkg.push_back(noise_byte());
    end
  endtask

  // One random table. Most carry a package at a random offset; the length
  // is sometimes cut short so that the table ends inside the package, and a
  // few bytes beyond the end are offered to show they are swallowed.
  task automatic random_table();
    bytes_t          q;
    bytes_t          pkg;
    logic [LenW-1:0] len;
    int              kind;
    int              p;
    int              full;
    int              counted;
    int              k;
    kind = $urandom_range(0, 99);
    q    = {};
    pkg  = {};
    if (kind < 15) begin
      // Short table: never matched, reports at its last byte.
      len = $urandom_range(1, 39);
      repeat (len + $urandom_range(0, 2)) q.push_back(noise_byte());
      counted = len;
    end else if (kind < 30) begin
      // Broken names: fragments of the name cut off at a random point.
      len = $urandom_range(40, 90);
      while (q.size() < len + 2) begin
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(1, 5);
          if (k >= 1) q.push_back(NameByte0);
          if (k >= 2) q.push_back(NameByte1);
          if (k >= 3) q.push_back(NameByte2);
          if (k >= 4) q.push_back(NameByte3);
          if (k >= 5) q.push_back(NameByte4);
          if ($urandom_range(0, 1) == 1) q.push_back(OpScope);
        end
        q.push_back(noise_byte());
      end
      counted = len;
    end else begin
      build_package(pkg);
      if (kind < 40) begin
        // Huge length: only the opening part of the table is sent.
        p   = $urandom_range(0, 8);
        len = $urandom_range(0, 1) ? 32'($urandom) : (32'($urandom) | 32'h8000_0000);
        if (len < 64) len = 64;
      end else if (kind < 60) begin
        // The table ends within or shortly after the package.
        p   = $urandom_range(27, 45);
        len = p + 13 + $urandom_range(0, 3);
      end else begin
        p   = $urandom_range(0, 40);
        len = p + pkg.size() + $urandom_range(0, 20);
        if (len < 40) len = 40;
      end
      full = p + pkg.size();
      repeat (p) q.push_back(noise_byte());
      foreach (pkg[i]) q.push_back(pkg[i]);
      if (kind < 40) begin
        repeat (3) q.push_back(noise_byte());
      end else begin
        while (q.size() < len + 3) q.push_back(noise_byte());
        k = len + $urandom_range(0, 3);
        while (q.size() > k && q.size() > full) void'(q.pop_back());
      end
      counted = (len < full) ? len : full;
    end
    run_table(len, q, q.size());
    payload_count += counted;
  endtask

  initial begin
    bytes_t q;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    payload_count = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset leaves a length of one: the first byte is also the last.
    q = {8'h00};
    stream_bytes(q, 1);

    // A length of zero behaves as one; the second byte is swallowed.
    q = {8'hFF, NameByte0};
    run_table(32'd0, q, 2);

    // Largest length, direct package with Zero then ByteData.
    q = {NameByte0, NameByte1, NameByte2, NameByte3, NameByte4, OpPackage,
         8'h00, 8'h02, OpZero, OpByteData, 8'hFF};
    run_table(32'hFFFF_FFFF, q, q.size());

    // Shortest length that is scanned, scoped package, ByteData then Zero.
    q = {NameByte0, NameByte1, NameByte2, NameByte3, NameByte4, OpScope,
         OpPackage, 8'h00, 8'h02, OpByteData, 8'h7F, OpZero};
    run_table(32'd40, q, q.size());

    while (payload_count < ItemTarget) random_table();

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("aml_s5_sleep_type_scanner_tb: clean");
    end else begin
      $display("aml_s5_sleep_type_scanner_tb: errors");
    end
    $finish;
  end

endmodule
